FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/bm5b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm5b_pkg
// widths, reset values, register codes and shared types of the 5x5 box mean
// ----------------------------------------------------------------------------
package bm5b_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int SAMPLE_W   = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int THR_W      = 8;
    localparam int ROW_W      = 12;
    localparam int CCOL_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int WIN       = 5;
    localparam int WIN_AREA  = WIN * WIN;
    localparam int HALF_WIN  = WIN / 2;
    localparam int LINES     = WIN - 1;
    localparam int SLOT_W    = $clog2(LINES);
    localparam int WORD_W    = LINES * SAMPLE_W;
    localparam int COLSUM_W  = $clog2(WIN * 255 + 1);
    localparam int SUM_W     = $clog2(WIN_AREA * 255 + 1);

    // widest line the width register can describe
    localparam int WIDTH_LIMIT = (1 << WIDTH_W) - 1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [THR_W-1:0]    THR_RESET    = 8'd128;

    localparam logic [SAMPLE_W-1:0] WHITE = 8'd255;
    localparam logic [SAMPLE_W-1:0] BLACK = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_MEAN_THRESHOLD = 2'd2
    } cfg_index_t;

    // window centre of one transaction, carried down the pipeline
    typedef struct packed {
        logic              center_valid;
        logic [ROW_W-1:0]  center_row;
        logic [CCOL_W-1:0] center_col;
        logic [SLOT_W-1:0] slot;
    } pos_t;

endpackage

FILE: sv/box_mean_5x5_binarize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_5x5_binarize_core
// 5x5 box mean over a raster stream of red samples, thresholded to 0 or 255
// ----------------------------------------------------------------------------
// Takes one red sample per transaction in raster order and returns one result
// per transaction: the position of the window centre two rows and two columns
// back, a flag telling whether that centre is interior (two pixels clear of
// every edge), and 255 or 0 from comparing the integer mean of the 25 original
// samples with mean_threshold (0 for border centres, which downstream keeps
// as they were). Throughput is one transaction per clock while out_stall is low;
// the accepting edge starts the line buffer read, the column sum is registered
// and the line written back as stage 1 moves on, and the output register loads
// as stage 2 moves on.
// The four previous lines live in a single line buffer of one 32-bit word per
// column, read when a sample is taken and written back as stage 1 moves on; a
// sample at the same column as the one ahead of it gets the written word
// forwarded. The line buffer has no reset and no clearing pass; it is fully
// written during the first four lines of a frame. in_stall rises only when every
// stage holds a result and out_stall is high. Configuration must be written only
// while the pipeline is empty (not enforced); a width above MAX_WIDTH acts as MAX_WIDTH.
// ----------------------------------------------------------------------------
module box_mean_5x5_binarize_core #(
    parameter int MAX_WIDTH = bm5b_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [bm5b_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bm5b_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bm5b_pkg::SAMPLE_W-1:0]   red_sample,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            center_valid,
    output logic [bm5b_pkg::ROW_W-1:0]      center_row,
    output logic [bm5b_pkg::CCOL_W-1:0]     center_col,
    output logic [bm5b_pkg::SAMPLE_W-1:0]   binary_value
);

    // longest usable line, bounded by what the width register can hold
    localparam int LINE_DEPTH = (MAX_WIDTH < bm5b_pkg::WIDTH_LIMIT)
                              ? MAX_WIDTH : bm5b_pkg::WIDTH_LIMIT;
    localparam int COL_W      = $clog2(LINE_DEPTH);

    // configuration registers
    logic [bm5b_pkg::WIDTH_W-1:0]  width_reg;
    logic [bm5b_pkg::HEIGHT_W-1:0] height_reg;
    logic [bm5b_pkg::THR_W-1:0]    thr_reg;

    // pipeline control
    logic in_accept, s1_move, s2_move;
    logic s1_load_ok, s2_load_ok, out_load_ok;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    // raster position of the incoming sample
    logic [COL_W-1:0] cur_col;
    bm5b_pkg::pos_t   cur_pos;

    // stage 1: line buffer read in flight
    logic [bm5b_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [COL_W-1:0]              s1_col_reg;
    bm5b_pkg::pos_t                s1_pos_reg;
    logic                          s1_fwd_reg;
    logic [bm5b_pkg::WORD_W-1:0]   s1_fwd_word_reg;
    logic [bm5b_pkg::WORD_W-1:0]   mem_rd_data;
    logic [bm5b_pkg::WORD_W-1:0]   line_word, line_word_next;
    logic [bm5b_pkg::COLSUM_W-1:0] col_sum_next;
    logic                          fwd_hit;

    // stage 2: column sum ready for the window
    logic [bm5b_pkg::COLSUM_W-1:0] s2_colsum_reg;
    bm5b_pkg::pos_t                s2_pos_reg;
    logic [bm5b_pkg::SAMPLE_W-1:0] win_binary;

    // output register
    logic                          out_center_valid_reg;
    logic [bm5b_pkg::ROW_W-1:0]    out_row_reg;
    logic [bm5b_pkg::CCOL_W-1:0]   out_col_reg;
    logic [bm5b_pkg::SAMPLE_W-1:0] out_bin_reg;

    // ------------------------------------------------------------------
    // configuration writes, index beyond the register list is dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bm5b_pkg::WIDTH_RESET;
            height_reg <= bm5b_pkg::HEIGHT_RESET;
            thr_reg    <= bm5b_pkg::THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bm5b_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[bm5b_pkg::WIDTH_W-1:0];
                end
                bm5b_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[bm5b_pkg::HEIGHT_W-1:0];
                end
                bm5b_pkg::CFG_MEAN_THRESHOLD:
                begin
                    thr_reg <= cfg_data[bm5b_pkg::THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: each stage loads when empty or when its holder moves on,
    // so bubbles collapse while the output waits
    // ------------------------------------------------------------------
    assign out_load_ok = !out_valid_reg || !out_stall;
    assign s2_load_ok  = !s2_valid_reg || out_load_ok;
    assign s1_load_ok  = !s1_valid_reg || s2_load_ok;

    assign s2_move   = s2_valid_reg && out_load_ok;
    assign s1_move   = s1_valid_reg && s2_load_ok;
    assign in_accept = in_valid && s1_load_ok;
    assign in_stall  = !s1_load_ok;

    always_comb
    begin
        s1_valid_next  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_move   ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
        out_valid_next = out_load_ok ? s2_move : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // raster counters and centre position
    // ------------------------------------------------------------------
    bm5b_raster #(
        .LINE_DEPTH (LINE_DEPTH),
        .COL_W      (COL_W)
    ) u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (cur_col),
        .pos          (cur_pos)
    );

    // ------------------------------------------------------------------
    // line buffer: read at accept, write back as stage 1 moves on
    // ------------------------------------------------------------------
    bm5b_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (cur_col),
        .rd_data (mem_rd_data),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (line_word_next)
    );

    // a sample read at the column being written in the same cycle sees the
    // old word from memory, so the new word is captured alongside it
    assign fwd_hit = s1_move && (s1_col_reg == cur_col);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg   <= red_sample;
            s1_col_reg      <= cur_col;
            s1_pos_reg      <= cur_pos;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_word_reg <= line_word_next;
        end
    end

    assign line_word = s1_fwd_reg ? s1_fwd_word_reg : mem_rd_data;

    // the slot of the oldest line takes the new sample; the column sum covers
    // the four stored lines plus the sample, order within the column is free
    always_comb
    begin
        col_sum_next = bm5b_pkg::COLSUM_W'(s1_sample_reg);
        for (int i = 0; i < bm5b_pkg::LINES; i++)
        begin
            col_sum_next = col_sum_next
                         + bm5b_pkg::COLSUM_W'(line_word[i*bm5b_pkg::SAMPLE_W +: bm5b_pkg::SAMPLE_W]);
            line_word_next[i*bm5b_pkg::SAMPLE_W +: bm5b_pkg::SAMPLE_W] =
                (s1_pos_reg.slot == bm5b_pkg::SLOT_W'(i))
                ? s1_sample_reg
                : line_word[i*bm5b_pkg::SAMPLE_W +: bm5b_pkg::SAMPLE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_colsum_reg <= col_sum_next;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // window sum and threshold, window advances with each transaction
    // ------------------------------------------------------------------
    bm5b_window u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .shift          (s2_move),
        .col_sum        (s2_colsum_reg),
        .mean_threshold (thr_reg),
        .center_valid   (s2_pos_reg.center_valid),
        .binary_value   (win_binary)
    );

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_center_valid_reg <= s2_pos_reg.center_valid;
            out_row_reg          <= s2_pos_reg.center_row;
            out_col_reg          <= s2_pos_reg.center_col;
            out_bin_reg          <= win_binary;
        end
    end

    assign out_valid    = out_valid_reg;
    assign center_valid = out_center_valid_reg;
    assign center_row   = out_row_reg;
    assign center_col   = out_col_reg;
    assign binary_value = out_bin_reg;

endmodule

FILE: sv/bm5b_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm5b_line_mem
// line buffer: one word per column holding the four stored lines
// ----------------------------------------------------------------------------
module bm5b_line_mem #(
    parameter int DEPTH  = bm5b_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(bm5b_pkg::MAX_WIDTH_DEF)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [bm5b_pkg::WORD_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [bm5b_pkg::WORD_W-1:0] wr_data
);

    logic [bm5b_pkg::WORD_W-1:0] mem [DEPTH];

    // read returns the old word when the same entry is written in this cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

FILE: sv/bm5b_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm5b_raster
// raster column and row counters and the window centre position
// ----------------------------------------------------------------------------
module bm5b_raster #(
    parameter int LINE_DEPTH = bm5b_pkg::MAX_WIDTH_DEF,
    parameter int COL_W      = $clog2(bm5b_pkg::MAX_WIDTH_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [bm5b_pkg::WIDTH_W-1:0]  image_width,
    input  logic [bm5b_pkg::HEIGHT_W-1:0] image_height,
    output logic [COL_W-1:0]              col,
    output bm5b_pkg::pos_t                pos
);

    localparam int CX_W = bm5b_pkg::WIDTH_W + 1;
    localparam int RX_W = bm5b_pkg::ROW_W + 1;

    logic [COL_W-1:0]              col_reg, col_next;
    logic [bm5b_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [bm5b_pkg::WIDTH_W-1:0]  eff_w;
    logic [bm5b_pkg::HEIGHT_W-1:0] eff_h;
    logic [CX_W-1:0]               col_x, w_x, cc_x;
    logic [RX_W-1:0]               row_x, h_x, cr_x;
    logic                          col_last, row_last;
    logic                          col_ge2, row_ge2, row_ge3;

    always_comb
    begin
        if (image_width > bm5b_pkg::WIDTH_W'(LINE_DEPTH))
        begin
            eff_w = bm5b_pkg::WIDTH_W'(LINE_DEPTH);
        end
        else if (image_width == '0)
        begin
            eff_w = bm5b_pkg::WIDTH_W'(1);
        end
        else
        begin
            eff_w = image_width;
        end
        eff_h = (image_height == '0) ? bm5b_pkg::HEIGHT_W'(1) : image_height;
    end

    assign col_x = CX_W'(col_reg);
    assign w_x   = CX_W'(eff_w);
    assign row_x = RX_W'(row_reg);
    assign h_x   = RX_W'(eff_h);

    assign col_last = (col_x + CX_W'(1)) >= w_x;
    assign row_last = (row_x + RX_W'(1)) >= h_x;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : bm5b_pkg::ROW_W'(row_x + RX_W'(1));
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // centre sits two columns back, borrowing a row at the line start, then two rows up
    assign col_ge2 = col_x >= CX_W'(bm5b_pkg::HALF_WIN);
    assign row_ge2 = row_x >= RX_W'(bm5b_pkg::HALF_WIN);
    assign row_ge3 = row_x >= RX_W'(bm5b_pkg::HALF_WIN + 1);

    always_comb
    begin
        if (col_ge2)
        begin
            cc_x = col_x - CX_W'(bm5b_pkg::HALF_WIN);
            cr_x = row_ge2 ? row_x - RX_W'(bm5b_pkg::HALF_WIN)
                           : row_x + h_x - RX_W'(bm5b_pkg::HALF_WIN);
        end
        else
        begin
            cc_x = col_x + w_x - CX_W'(bm5b_pkg::HALF_WIN);
            cr_x = row_ge3 ? row_x - RX_W'(bm5b_pkg::HALF_WIN + 1)
                           : row_x + h_x - RX_W'(bm5b_pkg::HALF_WIN + 1);
        end
    end

    // interior: centre at least two from every edge, reduced to the input position
    assign pos.center_valid = (col_x >= CX_W'(2 * bm5b_pkg::HALF_WIN)) && (col_x < w_x)
                           && (row_x >= RX_W'(2 * bm5b_pkg::HALF_WIN)) && (row_x < h_x);
    assign pos.center_row   = cr_x[bm5b_pkg::ROW_W-1:0];
    assign pos.center_col   = cc_x[bm5b_pkg::CCOL_W-1:0];
    assign pos.slot         = row_reg[bm5b_pkg::SLOT_W-1:0];
    assign col              = col_reg;

endmodule

FILE: sv/bm5b_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm5b_window
// 5x5 window sum from the five newest column sums and the threshold decision
// ----------------------------------------------------------------------------
module bm5b_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic [bm5b_pkg::COLSUM_W-1:0] col_sum,
    input  logic [bm5b_pkg::THR_W-1:0]    mean_threshold,
    input  logic                          center_valid,
    output logic [bm5b_pkg::SAMPLE_W-1:0] binary_value
);

    logic [bm5b_pkg::COLSUM_W-1:0] col_sums_reg  [bm5b_pkg::WIN];
    logic [bm5b_pkg::COLSUM_W-1:0] col_sums_next [bm5b_pkg::WIN];
    logic [bm5b_pkg::SUM_W-1:0]    total_next;
    logic [bm5b_pkg::SUM_W-1:0]    thr_scaled;

    // oldest column leaves, newest enters; the total is rebuilt from the five
    // columns so a stale column never lingers in it
    always_comb
    begin
        for (int i = 0; i < bm5b_pkg::WIN - 1; i++)
        begin
            col_sums_next[i] = col_sums_reg[i+1];
        end
        col_sums_next[bm5b_pkg::WIN-1] = col_sum;
        total_next = '0;
        for (int i = 0; i < bm5b_pkg::WIN; i++)
        begin
            total_next = total_next + bm5b_pkg::SUM_W'(col_sums_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bm5b_pkg::WIN; i++)
            begin
                col_sums_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            col_sums_reg <= col_sums_next;
        end
    end

    // sum / 25 >= t is the same as sum >= 25 * t
    assign thr_scaled   = bm5b_pkg::SUM_W'(mean_threshold)
                        * bm5b_pkg::SUM_W'(bm5b_pkg::WIN_AREA);
    assign binary_value = (center_valid && (total_next >= thr_scaled))
                        ? bm5b_pkg::WHITE : bm5b_pkg::BLACK;

endmodule

FILE: sv/bm5b_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm5b_checker
// port-level checks of the box mean core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bm5b_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            center_valid,
    input logic [bm5b_pkg::ROW_W-1:0]      center_row,
    input logic [bm5b_pkg::CCOL_W-1:0]     center_col,
    input logic [bm5b_pkg::SAMPLE_W-1:0]   binary_value
);

    // a result waiting under stall stays put
    `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(binary_value) && $stable(center_valid) && $stable(center_row) && $stable(center_col), "stalled result changed")

    // results are pure black or white
    `ASSERT_PROP(a_bin_levels, clk, rst_n, out_valid |-> (binary_value == bm5b_pkg::BLACK || binary_value == bm5b_pkg::WHITE), "result is neither 0 nor 255")

    // border centres carry no decision
    `ASSERT_NEVER(a_border_black, clk, rst_n, out_valid && !center_valid && binary_value != bm5b_pkg::BLACK, "border result not 0")

    // input back-pressure only when the output is full and held
    `ASSERT_PROP(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without a held result")

endmodule

bind box_mean_5x5_binarize_core bm5b_checker u_bm5b_checker (.*);
